>>> src/uswds_pkg.sv
package uswds_pkg;

  localparam int MAX_JOBS = 1024;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int REL_W    = 32;
  localparam int WGT_W    = 16;
  localparam int SLOT_W   = 33;
  localparam int WSUM_W   = 26;
  localparam int COST_W   = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             clr;       // start of a new set computation
    logic             ld_we;     // store one job
    logic             rd_en;     // scan read
    logic [IDX_W-1:0] idx;       // load write or scan read address
    logic             scan_clr;  // clear per-step accumulators
    logic             decide;    // commit one slot step
  } cmd_t;

  typedef struct packed {
    logic found;     // a released job is waiting
    logic any_left;  // some job is not yet served
  } stat_t;

endpackage

>>> src/uswds_ctrl.sv
module uswds_ctrl
  import uswds_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  in_last,
  input  logic  out_fire,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  in_ready,
  output logic  out_valid
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0] last_idx;

  assign last_idx = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.idx      = scan_r;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.idx  = count_r[IDX_W-1:0];
        if (in_fire) begin
          // a full store drops the job
          if (count_r < CNT_W'(MAX_JOBS)) begin
            cmd.ld_we = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last) begin
            cmd.clr      = 1'b1;
            cmd.scan_clr = 1'b1;
            scan_nxt     = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        scan_nxt  = scan_r + IDX_W'(1);
        if (scan_r == last_idx[IDX_W-1:0]) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide   = 1'b1;
        cmd.scan_clr = 1'b1;
        scan_nxt     = '0;
        if (stat.any_left) state_nxt = ST_SCAN;
        else state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          count_nxt = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

>>> src/uswds_dp.sv
module uswds_dp
  import uswds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [REL_W-1:0]  in_rel,
  input  logic [WGT_W-1:0]  in_wgt,
  output stat_t             stat,
  output logic [COST_W-1:0] cost,
  output logic              ovf
);

  logic [REL_W-1:0] rel_mem [MAX_JOBS];
  logic [WGT_W-1:0] wgt_mem [MAX_JOBS];
  logic             srv_mem [MAX_JOBS];

  logic [REL_W-1:0]  rel_q;
  logic [WGT_W-1:0]  wgt_q;
  logic              srv_q;
  logic              rd_v_r;
  logic [IDX_W-1:0]  idx_d_r;

  logic [SLOT_W-1:0] slot_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [WGT_W-1:0]  best_w_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              found_r;
  logic              pend_r;
  logic [REL_W-1:0]  minrel_r;
  logic [COST_W-1:0] cost_r;
  logic              ovf_r;

  logic              srv_we;
  logic [IDX_W-1:0]  srv_addr;
  logic              srv_d;
  logic [WSUM_W-1:0] delta;
  logic [COST_W:0]   sum;

  assign srv_we   = cmd.ld_we | (cmd.decide & found_r);
  assign srv_addr = cmd.ld_we ? cmd.idx : best_idx_r;
  assign srv_d    = ~cmd.ld_we;

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      rel_mem[cmd.idx] <= in_rel;
      wgt_mem[cmd.idx] <= in_wgt;
    end
    if (srv_we) srv_mem[srv_addr] <= srv_d;
    rel_q   <= rel_mem[cmd.idx];
    wgt_q   <= wgt_mem[cmd.idx];
    srv_q   <= srv_mem[cmd.idx];
    idx_d_r <= cmd.idx;
  end

  assign delta = wsum_r - WSUM_W'(best_w_r);
  assign sum   = {1'b0, cost_r} + (COST_W + 1)'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      found_r <= 1'b0;
      pend_r  <= 1'b0;
      slot_r  <= '0;
      wsum_r  <= '0;
      cost_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
      if (cmd.clr) begin
        slot_r <= '0;
        cost_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.decide) begin
        if (found_r) begin
          slot_r <= slot_r + SLOT_W'(1);
          if (sum[COST_W]) begin
            cost_r <= '1;
            ovf_r  <= 1'b1;
          end else begin
            cost_r <= sum[COST_W-1:0];
          end
        end else if (pend_r) begin
          // nothing waiting: jump to the next release
          slot_r <= SLOT_W'(minrel_r);
        end
      end
      if (cmd.scan_clr) begin
        found_r <= 1'b0;
        pend_r  <= 1'b0;
        wsum_r  <= '0;
      end else if (rd_v_r && !srv_q) begin
        if (SLOT_W'(rel_q) <= slot_r) begin
          wsum_r <= wsum_r + WSUM_W'(wgt_q);
          if (!found_r || wgt_q > best_w_r) begin
            found_r    <= 1'b1;
            best_w_r   <= wgt_q;
            best_idx_r <= idx_d_r;
          end
        end else if (!pend_r || rel_q < minrel_r) begin
          pend_r   <= 1'b1;
          minrel_r <= rel_q;
        end
      end
    end
  end

  assign stat.found    = found_r;
  assign stat.any_left = found_r | pend_r;
  assign cost          = cost_r;
  assign ovf           = ovf_r;

endmodule

>>> src/unit_slot_weighted_delay_scheduler.sv
// Load: one job beat per cycle into the job store; the set ends on tlast.
// Compute: each slot step scans the stored jobs through the single job-store
// read port; a set of n jobs takes at most 2n + 1 steps.
// One set is handled at a time; the next set loads after the result is taken.
// Reset (rst_n low, synchronous) clears control and accumulators, not the store.
module unit_slot_weighted_delay_scheduler
  import uswds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // release_slot[31:0], weight[47:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // total_cost[63:0]
  output logic        out_tuser   // overflow
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;
  logic  out_fire;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  uswds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_tlast),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  uswds_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .in_rel (in_tdata[31:0]),
    .in_wgt (in_tdata[47:32]),
    .stat   (stat),
    .cost   (out_tdata),
    .ovf    (out_tuser)
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("load and result overlap");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (&out_tdata)) else $error("overflow without saturation");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> in_tready) else $error("no load after result");

endmodule
